>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ice_pkg.sv
// Types and constants of the indirect colortable engine.
package ice_pkg;

    localparam int PEN_ENTRIES = 1024;
    localparam int IND_ENTRIES = 256;
    localparam int PEN_AW      = (PEN_ENTRIES > 1) ? $clog2(PEN_ENTRIES) : 1;
    localparam int IND_AW      = (IND_ENTRIES > 1) ? $clog2(IND_ENTRIES) : 1;
    localparam int RGB_W       = 24;
    localparam int MAX_DEPTH   = 32;
    localparam int DIV_STEPS   = 16;
    localparam int DIV_CW      = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        OP_SET_IND  = 2'd0,
        OP_SET_PEN  = 2'd1,
        OP_READ_PEN = 2'd2,
        OP_MASK     = 2'd3
    } t_ice_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_IND_CHECK,
        ST_PEN_WRITE,
        ST_DIVIDE,
        ST_MULTIPLY,
        ST_ADD,
        ST_SCAN,
        ST_DONE
    } t_ice_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  pen;
        logic [7:0]  ind_index;
        logic [23:0] rgb_value;
        logic [15:0] color_code;
        logic [7:0]  trans_index;
        logic [9:0]  gfx_colorbase;
        logic [10:0] gfx_colors;
        logic [10:0] gfx_granularity;
        logic [5:0]  gfx_depth;
    } t_ice_req;

    typedef struct packed {
        logic        status;
        logic [23:0] pen_color_out;
        logic [31:0] match_mask;
    } t_ice_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic clr_step;
        logic ind_rd;
        logic ind_wr;
        logic pen_wr;
        logic color_rd;
        logic addr_clr;
        logic scan_rd;
        logic div_init;
        logic div_step;
        logic mul_step;
        logic add_step;
        logic rsp_load;
    } t_ice_ctl;

    // Datapath to controller status.
    typedef struct packed {
        t_ice_op op;
        logic    req_err;
        logic    ind_diff;
        logic    clr_last;
        logic    div_last;
        logic    scan_go;
    } t_ice_sts;

endpackage

>>> hw/rtl/ice_if.sv
// Request and response channel interfaces of the colortable engine.
interface ice_req_if;
    logic              valid;
    logic              ready;
    ice_pkg::t_ice_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ice_rsp_if;
    logic              valid;
    logic              ready;
    ice_pkg::t_ice_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/ice_ctrl.sv
// Sequencing state machine of the colortable engine.
module ice_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_rsp_free,
    input  ice_pkg::t_ice_sts i_sts,
    output ice_pkg::t_ice_ctl o_ctl,
    output logic              o_ready
);

    ice_pkg::t_ice_state r_state;
    ice_pkg::t_ice_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ice_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ready = 1'b0;
        case (r_state)
            ice_pkg::ST_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ice_pkg::ST_IDLE;
                end
            end
            ice_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = ice_pkg::ST_DECODE;
                end
            end
            ice_pkg::ST_DECODE: begin
                if (i_sts.req_err) begin
                    n_state = ice_pkg::ST_DONE;
                end else begin
                    case (i_sts.op)
                        ice_pkg::OP_SET_IND: begin
                            o_ctl.ind_rd = 1'b1;
                            n_state      = ice_pkg::ST_IND_CHECK;
                        end
                        ice_pkg::OP_SET_PEN: begin
                            o_ctl.ind_rd = 1'b1;
                            n_state      = ice_pkg::ST_PEN_WRITE;
                        end
                        ice_pkg::OP_READ_PEN: begin
                            o_ctl.color_rd = 1'b1;
                            n_state        = ice_pkg::ST_DONE;
                        end
                        ice_pkg::OP_MASK: begin
                            o_ctl.div_init = 1'b1;
                            n_state        = ice_pkg::ST_DIVIDE;
                        end
                        default: begin
                            n_state = ice_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ice_pkg::ST_IND_CHECK: begin
                if (i_sts.ind_diff) begin
                    o_ctl.ind_wr   = 1'b1;
                    o_ctl.addr_clr = 1'b1;
                    n_state        = ice_pkg::ST_SCAN;
                end else begin
                    n_state = ice_pkg::ST_DONE;
                end
            end
            ice_pkg::ST_PEN_WRITE: begin
                o_ctl.pen_wr = 1'b1;
                n_state      = ice_pkg::ST_DONE;
            end
            ice_pkg::ST_DIVIDE: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ice_pkg::ST_MULTIPLY;
                end
            end
            ice_pkg::ST_MULTIPLY: begin
                o_ctl.mul_step = 1'b1;
                n_state        = ice_pkg::ST_ADD;
            end
            ice_pkg::ST_ADD: begin
                o_ctl.add_step = 1'b1;
                n_state        = ice_pkg::ST_SCAN;
            end
            ice_pkg::ST_SCAN: begin
                if (i_sts.scan_go) begin
                    o_ctl.scan_rd = 1'b1;
                end else begin
                    n_state = ice_pkg::ST_DONE;
                end
            end
            ice_pkg::ST_DONE: begin
                if (i_rsp_free) begin
                    o_ctl.rsp_load = 1'b1;
                    n_state        = ice_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ice_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/ice_dp.sv
// Datapath of the colortable engine: tables, divider, mask builder.
module ice_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ice_pkg::t_ice_req i_req,
    input  ice_pkg::t_ice_ctl i_ctl,
    output ice_pkg::t_ice_sts o_sts,
    output ice_pkg::t_ice_rsp o_rsp
);

    localparam int PAW = ice_pkg::PEN_AW;
    localparam int IAW = ice_pkg::IND_AW;
    localparam int CW  = ice_pkg::RGB_W;

    // tables
    logic [CW-1:0]             r_ind_mem [ice_pkg::IND_ENTRIES];
    logic [ice_pkg::IND_ENTRIES-1:0] r_ind_written;
    logic [IAW-1:0]            r_pen_ind_mem [ice_pkg::PEN_ENTRIES];
    logic [CW-1:0]             r_pen_col_mem [ice_pkg::PEN_ENTRIES];

    logic [CW-1:0]             r_ind_rd;
    logic                      r_ind_rd_valid;
    logic [IAW-1:0]            r_pen_ind_rd;
    logic [CW-1:0]             r_pen_col_rd;

    ice_pkg::t_ice_req         r_req;
    logic [PAW:0]              r_addr;
    logic [IAW-1:0]            r_clr_ind;
    logic                      r_scan_pend;
    logic [PAW-1:0]            r_pend_addr;
    logic [4:0]                r_pend_bit;
    logic [5:0]                r_idx;
    logic [11:0]               r_rem;
    logic [ice_pkg::DIV_CW-1:0] r_div_cnt;
    logic [21:0]               r_prod;
    logic [22:0]               r_entry;
    logic [31:0]               r_mask;

    ice_pkg::t_ice_op          op;
    logic [IAW-1:0]            ind_addr;
    logic [PAW-1:0]            pen_addr;
    logic                      ind_ok;
    logic                      pen_ok;
    logic                      pre_err;
    logic                      entry_err;
    logic [22:0]               mask_pos;
    logic                      mask_in;
    logic                      scan_go;
    logic [PAW-1:0]            rd_addr;
    logic                      rd_en;
    logic [11:0]               div_try;
    logic [11:0]               div_dsr;
    logic                      div_ge;
    logic                      pend_hit;
    logic                      color_hit;

    function automatic logic [CW-1:0] rainbow(input logic [PAW:0] p);
        logic [2:0] b;
        b = 3'(p);
        return {{8{b[0]}}, {8{b[1]}}, {8{b[2]}}};
    endfunction

    assign op       = ice_pkg::t_ice_op'(r_req.cmd);
    assign ind_addr = IAW'(r_req.ind_index);
    assign pen_addr = PAW'(r_req.pen);
    assign ind_ok   = 32'(r_req.ind_index) < 32'(ice_pkg::IND_ENTRIES);
    assign pen_ok   = 32'(r_req.pen) < 32'(ice_pkg::PEN_ENTRIES);

    always_comb begin
        case (op)
            ice_pkg::OP_SET_IND:  pre_err = !ind_ok;
            ice_pkg::OP_SET_PEN:  pre_err = !pen_ok || !ind_ok;
            ice_pkg::OP_READ_PEN: pre_err = !pen_ok;
            ice_pkg::OP_MASK:     pre_err = (r_req.gfx_colors == '0) ||
                                            (r_req.gfx_depth > 6'(ice_pkg::MAX_DEPTH));
            default:              pre_err = 1'b1;
        endcase
    end

    // mask scan walks entry+idx for up to depth pens, reads none past the table end
    assign entry_err = 32'(r_entry) >= 32'(ice_pkg::PEN_ENTRIES);
    assign mask_pos  = r_entry + 23'(r_idx);
    assign mask_in   = 32'(mask_pos) < 32'(ice_pkg::PEN_ENTRIES);

    always_comb begin
        if (op == ice_pkg::OP_MASK) begin
            scan_go = !entry_err && (r_idx < r_req.gfx_depth);
            rd_addr = mask_pos[PAW-1:0];
            rd_en   = i_ctl.scan_rd && mask_in;
        end else begin
            scan_go = r_addr < (PAW + 1)'(ice_pkg::PEN_ENTRIES);
            rd_addr = r_addr[PAW-1:0];
            rd_en   = i_ctl.scan_rd;
        end
    end

    // restoring remainder, one dividend bit per step
    assign div_try = {r_rem[10:0], r_req.color_code[r_div_cnt]};
    assign div_dsr = {1'b0, r_req.gfx_colors};
    assign div_ge  = div_try >= div_dsr;

    assign pend_hit  = r_scan_pend && (32'(r_pen_ind_rd) == 32'(r_req.trans_index)) &&
                       (op == ice_pkg::OP_MASK);
    assign color_hit = r_scan_pend && (r_pen_ind_rd == ind_addr) &&
                       (op == ice_pkg::OP_SET_IND);

    // indirect colour store
    always_ff @(posedge i_clk) begin
        if (i_ctl.ind_wr) begin
            r_ind_mem[ind_addr] <= r_req.rgb_value;
        end
        if (i_ctl.ind_rd) begin
            r_ind_rd       <= r_ind_mem[ind_addr];
            r_ind_rd_valid <= r_ind_written[ind_addr];
        end
    end

    // pen to indirect index table
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) begin
            r_pen_ind_mem[r_addr[PAW-1:0]] <= r_clr_ind;
        end else if (i_ctl.pen_wr) begin
            r_pen_ind_mem[pen_addr] <= ind_addr;
        end
        if (rd_en) begin
            r_pen_ind_rd <= r_pen_ind_mem[rd_addr];
        end
    end

    // resolved pen colours
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) begin
            r_pen_col_mem[r_addr[PAW-1:0]] <= rainbow(r_addr);
        end else if (i_ctl.pen_wr) begin
            r_pen_col_mem[pen_addr] <= r_ind_rd_valid ? r_ind_rd : '0;
        end else if (color_hit) begin
            r_pen_col_mem[r_pend_addr] <= r_req.rgb_value;
        end
        if (i_ctl.color_rd) begin
            r_pen_col_rd <= r_pen_col_mem[pen_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ind_written <= '0;
            r_addr        <= '0;
            r_clr_ind     <= '0;
            r_scan_pend   <= 1'b0;
        end else begin
            r_scan_pend <= rd_en;
            if (i_ctl.ind_wr) begin
                r_ind_written[ind_addr] <= 1'b1;
            end
            if (i_ctl.clr_step) begin
                r_addr    <= r_addr + 1'b1;
                r_clr_ind <= (r_clr_ind == IAW'(ice_pkg::IND_ENTRIES - 1)) ?
                             '0 : r_clr_ind + 1'b1;
            end else if (i_ctl.addr_clr) begin
                r_addr <= '0;
            end else if (i_ctl.scan_rd && (op == ice_pkg::OP_SET_IND)) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req  <= i_req;
            r_mask <= '0;
        end else if (pend_hit) begin
            r_mask[r_pend_bit] <= 1'b1;
        end
        if (i_ctl.div_init) begin
            r_rem     <= '0;
            r_div_cnt <= ice_pkg::DIV_CW'(ice_pkg::DIV_STEPS - 1);
        end else if (i_ctl.div_step) begin
            r_rem     <= div_ge ? (div_try - div_dsr) : div_try;
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        if (i_ctl.mul_step) begin
            r_prod <= 22'(r_rem[10:0]) * 22'(r_req.gfx_granularity);
        end
        if (i_ctl.add_step) begin
            r_entry <= 23'(r_prod) + 23'(r_req.gfx_colorbase);
            r_idx   <= '0;
        end else if (i_ctl.scan_rd && (op == ice_pkg::OP_MASK)) begin
            r_idx <= r_idx + 1'b1;
        end
        if (rd_en) begin
            r_pend_addr <= rd_addr;
            r_pend_bit  <= r_idx[4:0];
        end
    end

    assign o_sts.op       = op;
    assign o_sts.req_err  = pre_err;
    assign o_sts.ind_diff = !r_ind_rd_valid || (r_ind_rd != r_req.rgb_value);
    assign o_sts.clr_last = r_addr == (PAW + 1)'(ice_pkg::PEN_ENTRIES - 1);
    assign o_sts.div_last = r_div_cnt == '0;
    assign o_sts.scan_go  = scan_go;

    assign o_rsp.status        = pre_err || ((op == ice_pkg::OP_MASK) && entry_err);
    assign o_rsp.pen_color_out = ((op == ice_pkg::OP_READ_PEN) && !pre_err) ?
                                 r_pen_col_rd : '0;
    assign o_rsp.match_mask    = r_mask;

endmodule

>>> hw/rtl/indirect_colortable_engine.sv
// Top level of the indirect colortable engine: controller, datapath, response register.
// Use: one request on i_req (valid/ready) carries a command and all its operands; one
// response on o_rsp carries status, pen colour and transparency mask for each request.
// After reset a clearing pass over all PEN_ENTRIES pens loads the pen tables with
// their start values; i_req.ready stays low until it ends.
// One request is worked at a time. After decoding, each command takes these steps:
//   set indirect colour: read the entry and compare; a new colour or a first write to
//     the entry is written and every pen is then scanned, one pen a cycle, through the
//     single read port of the pen index table
//   point pen at entry: read the entry, then write the pen; read pen colour: one read
//   transparency mask: 16 remainder steps, multiply, add, then one pen a cycle for the
//     scan, which is skipped when the first pen lies past the table
//   rejected operands: straight to the response
// The response sits in an output register; the next request is taken in the cycle
// after the response is loaded, even while the receiver still stalls. When the receiver
// holds o_rsp.ready low and a second response is done, the engine holds it and waits.
`include "assert_macros.svh"

module indirect_colortable_engine (
    input logic        i_clk,
    input logic        i_rst_n,
    ice_req_if.sink    i_req,
    ice_rsp_if.source  o_rsp
);

    ice_pkg::t_ice_ctl w_ctl;
    ice_pkg::t_ice_sts w_sts;
    ice_pkg::t_ice_rsp w_rsp;
    logic              w_ready;
    logic              w_rsp_free;

    logic              r_rsp_valid;
    ice_pkg::t_ice_rsp r_rsp;

    // output register frees when empty or drained in this cycle
    assign w_rsp_free = !r_rsp_valid || o_rsp.ready;

    ice_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_free  (w_rsp_free),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl),
        .o_ready     (w_ready)
    );

    ice_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.payload),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_rsp   (w_rsp)
    );

    assign i_req.ready = w_ready;

    // hold the response until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_ctl.rsp_load) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.rsp_load) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    `ASSERT_IMPLY(a_no_req_while_clearing, w_ctl.clr_step, !i_req.ready, "request taken during clearing pass")
    `ASSERT_IMPLY(a_rsp_not_overwritten, w_ctl.rsp_load, !r_rsp_valid || o_rsp.ready, "pending response overwritten")
    `ASSERT_IMPLY(a_err_rsp_empty, o_rsp.valid && o_rsp.payload.status, (o_rsp.payload.match_mask == '0) && (o_rsp.payload.pen_color_out == '0), "error response carries data")
    `ASSERT_NEXT(a_busy_after_accept, i_req.valid && i_req.ready, !i_req.ready, "second request taken while busy")

endmodule

>>> test/ice_rsp_checker.sv
// Response checker of the colortable engine: tracks the tables and compares every response.
`timescale 1ns / 100ps

module ice_rsp_checker
    import ice_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  logic     i_req_ready,
    input  t_ice_req i_req,
    input  logic     i_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_ice_rsp i_rsp,
    output int       o_errors,
    output int       o_outstanding,
    output int       o_checked
);

    // Shadow copy of the engine's tables.
    logic [RGB_W-1:0]  ind_rgb     [IND_ENTRIES];
    logic              ind_written [IND_ENTRIES];
    logic [IND_AW-1:0] pen_link    [PEN_ENTRIES];
    logic [RGB_W-1:0]  pen_rgb     [PEN_ENTRIES];

    // Responses owed by the engine, oldest first.
    t_ice_rsp awaited_rsp[$];

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
        o_checked     = 0;
    end

    function automatic void load_start_tables();
        for (int e = 0; e < IND_ENTRIES; e++) begin
            ind_rgb[e]     = '0;
            ind_written[e] = 1'b0;
        end
        // Pens start on entry pen mod entries, coloured by a three-bit rainbow.
        for (int p = 0; p < PEN_ENTRIES; p++) begin
            pen_link[p] = IND_AW'(p % IND_ENTRIES);
            pen_rgb[p]  = {{8{p[0]}}, {8{p[1]}}, {8{p[2]}}};
        end
    endfunction

    // Apply one request to the shadow tables and return the response it owes.
    function automatic t_ice_rsp resolve_request(t_ice_req r);
        t_ice_rsp        rsp;
        longint unsigned first;
        longint unsigned code_l;
        longint unsigned colors_l;
        longint unsigned gran_l;
        longint unsigned span;
        rsp = '0;
        case (t_ice_op'(r.cmd))
            OP_SET_IND: begin
                if (int'(r.ind_index) >= IND_ENTRIES) begin
                    rsp.status = 1'b1;
                end else if (!ind_written[r.ind_index] || ind_rgb[r.ind_index] != r.rgb_value) begin
                    ind_rgb[r.ind_index]     = r.rgb_value;
                    ind_written[r.ind_index] = 1'b1;
                    for (int p = 0; p < PEN_ENTRIES; p++) begin
                        if (pen_link[p] == r.ind_index) begin
                            pen_rgb[p] = r.rgb_value;
                        end
                    end
                end
            end
            OP_SET_PEN: begin
                if (int'(r.pen) >= PEN_ENTRIES || int'(r.ind_index) >= IND_ENTRIES) begin
                    rsp.status = 1'b1;
                end else begin
                    pen_link[r.pen] = r.ind_index;
                    pen_rgb[r.pen]  = ind_rgb[r.ind_index];
                end
            end
            OP_READ_PEN: begin
                if (int'(r.pen) >= PEN_ENTRIES) begin
                    rsp.status = 1'b1;
                end else begin
                    rsp.pen_color_out = pen_rgb[r.pen];
                end
            end
            default: begin
                if (r.gfx_colors == '0 || int'(r.gfx_depth) > MAX_DEPTH) begin
                    rsp.status = 1'b1;
                end else begin
                    code_l   = r.color_code;
                    colors_l = r.gfx_colors;
                    gran_l   = r.gfx_granularity;
                    first    = r.gfx_colorbase;
                    first    = first + (code_l % colors_l) * gran_l;
                    if (first >= PEN_ENTRIES) begin
                        rsp.status = 1'b1;
                    end else begin
                        // Clip the window at the last pen.
                        span = r.gfx_depth;
                        if (span > PEN_ENTRIES - first) begin
                            span = PEN_ENTRIES - first;
                        end
                        for (int b = 0; b < span; b++) begin
                            if (pen_link[first + b] == r.trans_index) begin
                                rsp.match_mask[b] = 1'b1;
                            end
                        end
                    end
                end
            end
        endcase
        return rsp;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_errors++;
        end
    endtask

    // Compare the response first so that a request taken in the same cycle cannot hide a
    // response that nothing asked for.
    always @(posedge i_clk) begin
        t_ice_rsp want;
        if (!i_rst_n) begin
            load_start_tables();
            awaited_rsp.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                o_checked++;
                if (awaited_rsp.size() == 0) begin
                    $error("response with no request outstanding");
                    o_errors++;
                end else begin
                    want = awaited_rsp.pop_front();
                    check_field("status", 32'(want.status), 32'(i_rsp.status));
                    check_field("pen_color_out", 32'(want.pen_color_out),
                                32'(i_rsp.pen_color_out));
                    check_field("match_mask", want.match_mask, i_rsp.match_mask);
                end
            end
            if (i_req_valid && i_req_ready) begin
                awaited_rsp.push_back(resolve_request(i_req));
            end
        end
        o_outstanding = awaited_rsp.size();
    end

endmodule

>>> test/indirect_colortable_engine_tb.sv
// Testbench top of the colortable engine: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module indirect_colortable_engine_tb;

    import ice_pkg::*;

    // Random requests after the directed ones; the last TAIL_ITEMS run without idling.
    localparam int RANDOM_ITEMS = 555;
    localparam int TAIL_ITEMS   = 60;
    // A changing colour write scans every pen before it answers, and the clearing pass
    // after reset writes every pen. Allow several times the longer of the two.
    localparam int STALL_LIMIT  = 6000;
    // Cycles to keep watching once nothing is owed, so that a stray response shows up.
    localparam int DRAIN_CYCLES = 64;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    ice_req_if req_ch ();
    ice_rsp_if rsp_ch ();

    int errors;
    int outstanding;
    int checked;

    int          op_count [4];
    bit          tail_calm;
    int unsigned quiet_items;
    int unsigned hold_left;
    int unsigned calm_left;
    int          idle_run;

    indirect_colortable_engine u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    ice_rsp_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_ch.valid),
        .i_req_ready   (req_ch.ready),
        .i_req         (req_ch.payload),
        .i_rsp_valid   (rsp_ch.valid),
        .i_rsp_ready   (rsp_ch.ready),
        .i_rsp         (rsp_ch.payload),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // ------------------------------------------------------------------------------------
    // Request builders. Every field starts random so that the operands a command ignores
    // still see both values on every bit; the builder then sets the ones that matter.
    // ------------------------------------------------------------------------------------
    function automatic t_ice_req op_request(t_ice_op op);
        logic [127:0] noise;
        t_ice_req     r;
        noise = {$urandom, $urandom, $urandom, $urandom};
        r     = noise[$bits(t_ice_req)-1:0];
        r.cmd = op;
        return r;
    endfunction

    function automatic t_ice_req set_colour(logic [7:0] ind, logic [23:0] rgb);
        t_ice_req r;
        r           = op_request(OP_SET_IND);
        r.ind_index = ind;
        r.rgb_value = rgb;
        return r;
    endfunction

    function automatic t_ice_req link_pen(logic [9:0] pen, logic [7:0] ind);
        t_ice_req r;
        r           = op_request(OP_SET_PEN);
        r.pen       = pen;
        r.ind_index = ind;
        return r;
    endfunction

    function automatic t_ice_req read_pen(logic [9:0] pen);
        t_ice_req r;
        r     = op_request(OP_READ_PEN);
        r.pen = pen;
        return r;
    endfunction

    function automatic t_ice_req mask_query(logic [9:0] base, logic [10:0] colors,
                                            logic [10:0] gran, logic [15:0] code,
                                            logic [7:0] trans, logic [5:0] depth);
        t_ice_req r;
        r                 = op_request(OP_MASK);
        r.gfx_colorbase   = base;
        r.gfx_colors      = colors;
        r.gfx_granularity = gran;
        r.color_code      = code;
        r.trans_index     = trans;
        r.gfx_depth       = depth;
        return r;
    endfunction

    // Half the entries come from a small hot set so that links, colour writes and mask
    // queries keep meeting one another; the other half range over the whole table.
    function automatic logic [7:0] pick_entry();
        return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    endfunction

    // Likewise keep half the pens in the low window where most mask queries look.
    function automatic logic [9:0] pick_pen();
        return ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 63)) : 10'($urandom);
    endfunction

    // Mix: 15% colour writes (the slow ones), 30% pen links, 25% pen reads, 30% masks.
    function automatic t_ice_req random_request();
        t_ice_req    r;
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 3) begin
            r = set_colour(pick_entry(), 24'($urandom));
            // Draw from a tiny palette now and then so that unchanged writes happen.
            case ($urandom_range(0, 5))
                0: r.rgb_value = 24'h000000;
                1: r.rgb_value = 24'hFFFFFF;
                2: r.rgb_value = 24'h8040C0;
                default: ;
            endcase
        end else if (roll < 9) begin
            r = link_pen(pick_pen(), pick_entry());
        end else if (roll < 14) begin
            r = read_pen(pick_pen());
        end else if ($urandom_range(0, 7) == 0) begin
            // Raw operands: zero groups, oversized depth and far-off starts.
            r = op_request(OP_MASK);
        end else begin
            r = mask_query(pick_pen(), 11'($urandom_range(1, 4)), 11'($urandom_range(0, 32)),
                           16'($urandom), pick_entry(), 6'($urandom_range(0, 32)));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Present one request and hold it until the engine takes it. Afterwards either keep
    // valid high for the next one or drop it for an idle burst. Quiet stretches of
    // back-to-back requests are mixed in, and the tail of the run has no idling at all.
    // ------------------------------------------------------------------------------------
    task automatic push_request(t_ice_req r);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready) begin
            @(posedge clk);
        end
        op_count[r.cmd]++;
        if (tail_calm) begin
            // no idling near the end
        end else if (quiet_items != 0) begin
            quiet_items--;
        end else if ($urandom_range(0, 15) == 0) begin
            quiet_items = $urandom_range(8, 30);
        end else if ($urandom_range(0, 2) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Response side: stall in bursts, with calm stretches in between. The engine parks a
    // second finished response while ready is low, so stalls can also hold off later
    // requests.
    // ------------------------------------------------------------------------------------
    always @(posedge clk) begin
        if (tail_calm) begin
            rsp_ch.ready <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (calm_left != 0) begin
            calm_left--;
            rsp_ch.ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    calm_left = $urandom_range(30, 150);
                    rsp_ch.ready <= 1'b1;
                end
                1, 2, 3: begin
                    hold_left = $urandom_range(0, 3);
                    rsp_ch.ready <= 1'b0;
                end
                default: rsp_ch.ready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------------------------
    // Watchdog: count cycles in which neither channel moves a request or a response.
    // ------------------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("no progress for %0d cycles, %0d responses still owed",
                     STALL_LIMIT, outstanding);
            $display("FAIL indirect_colortable_engine");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // ------------------------------------------------------------------------------------
    // Main sequence: reset, directed requests, random requests, drain, verdict.
    // ------------------------------------------------------------------------------------
    initial begin
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        tail_calm      = 1'b0;
        quiet_items    = 0;
        hold_left      = 0;
        calm_left      = 0;
        idle_run       = 0;
        op_count       = '{default: 0};

        // Hold reset; after its release the engine clears its tables on its own.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Start values: black, white and the top pen of the rainbow.
        push_request(read_pen(10'd0));
        push_request(read_pen(10'd7));
        push_request(read_pen(10'd1023));
        // Pen 0 starts on entry 0, so bit 0 alone is set.
        push_request(mask_query(10'd0, 11'd1, 11'd0, 16'd0, 8'd0, 6'd32));
        // Entry never written: a write of black must still repaint its pens.
        push_request(set_colour(8'd0, 24'h000000));
        push_request(read_pen(10'd256));
        // Same colour again: nothing changes.
        push_request(set_colour(8'd0, 24'h000000));
        push_request(set_colour(8'd255, 24'hFFFFFF));
        push_request(read_pen(10'd1023));
        push_request(link_pen(10'd1023, 8'd0));
        push_request(link_pen(10'd0, 8'd255));
        push_request(read_pen(10'd0));
        push_request(mask_query(10'd0, 11'd1, 11'd0, 16'd0, 8'd255, 6'd32));
        // Rejected masks: zero groups, depth just above and far above the limit.
        push_request(mask_query(10'd0, 11'd0, 11'd1, 16'd5, 8'd0, 6'd8));
        push_request(mask_query(10'd0, 11'd1, 11'd0, 16'd0, 8'd0, 6'd33));
        push_request(mask_query(10'd0, 11'd1, 11'd0, 16'd0, 8'd0, 6'd63));
        // Zero depth is legal and gives an empty mask.
        push_request(mask_query(10'd0, 11'd1, 11'd0, 16'd0, 8'd255, 6'd0));
        // First pen one past the end.
        push_request(mask_query(10'd1023, 11'd2, 11'd1, 16'd1, 8'd0, 6'd32));
        // Window clipped at the last pen; pen 1023 now sits on entry 0.
        push_request(mask_query(10'd1000, 11'd1, 11'd0, 16'd0, 8'd0, 6'd32));
        // Large groups and granularity, up to the largest: the start lands far out of range.
        push_request(mask_query(10'd0, 11'd1024, 11'd1024, 16'hFFFF, 8'd0, 6'd32));
        push_request(mask_query(10'd1023, 11'd2047, 11'd2047, 16'hFFFF, 8'd255, 6'd32));
        // Remainder of zero cancels a huge granularity.
        push_request(mask_query(10'd0, 11'd1023, 11'd2047, 16'd1023, 8'd255, 6'd32));
        push_request(set_colour(8'd128, 24'h5A5A5A));
        push_request(read_pen(10'd640));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - TAIL_ITEMS) begin
                tail_calm = 1'b1;
            end
            push_request(random_request());
        end
        req_ch.valid <= 1'b0;

        // Wait for every owed response, sampling away from the clock edge.
        do begin
            @(negedge clk);
        end while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d colour writes, %0d pen links, %0d pen reads,",
                 op_count[OP_SET_IND] + op_count[OP_SET_PEN] + op_count[OP_READ_PEN]
                 + op_count[OP_MASK], op_count[OP_SET_IND], op_count[OP_SET_PEN],
                 op_count[OP_READ_PEN]);
        $display("%0d mask queries; %0d responses checked, %0d mismatches",
                 op_count[OP_MASK], checked, errors);
        if (errors == 0) begin
            $display("PASS indirect_colortable_engine");
        end else begin
            $display("FAIL indirect_colortable_engine");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ice_pkg.sv
hw/rtl/ice_if.sv
hw/rtl/ice_ctrl.sv
hw/rtl/ice_dp.sv
hw/rtl/indirect_colortable_engine.sv
test/ice_rsp_checker.sv
test/indirect_colortable_engine_tb.sv
